>>> rtl/lwsn_pkg.sv
// ----------------------------------------------------------------------------
// lwsn_pkg: shared constants and table functions
// Widths, fixed-point constants and the sigmoid table generator used by the
// local window sigmoid neuron.
// ----------------------------------------------------------------------------
package lwsn_pkg;

	localparam int TAPS          = 3;
	localparam int SAMPLE_BITS   = 16;
	localparam int INDEX_BITS    = 8;
	localparam int FRAC_SHIFT    = 12;
	localparam int ACT_BITS      = 13;
	localparam int WIN_DEPTH     = TAPS - 1;
	localparam int FILL_BITS     = $clog2(TAPS);
	localparam int TABLE_SIZE    = 1 << INDEX_BITS;
	localparam int PROD_BITS     = 2 * SAMPLE_BITS;
	localparam int SUM_BITS      = PROD_BITS + $clog2(TAPS);
	localparam int SHIFT_BITS    = SUM_BITS - FRAC_SHIFT;
	localparam int BIASED_BITS   = SHIFT_BITS + 1;
	localparam int S_DATA_BITS   = TAPS * SAMPLE_BITS + SAMPLE_BITS;
	localparam int M_DATA_BITS   = ((ACT_BITS + 7) / 8) * 8;

	localparam logic [63:0] Q48_ONE = 64'd1 << 48;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic [ACT_BITS-1:0] act_t;

	// Computes (a * b) >> 48 for operands below 2^49.
	function automatic logic [63:0] mul_q48(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah;
		logic [63:0] al;
		logic [63:0] bh;
		logic [63:0] bl;
		logic [63:0] lo;
		logic [63:0] mid;
		ah  = a >> 32;
		al  = a & 64'hFFFF_FFFF;
		bh  = b >> 32;
		bl  = b & 64'hFFFF_FFFF;
		lo  = al * bl;
		mid = ah * bl + al * bh;
		return ((ah * bh) << 16) + (mid >> 16) + (((mid & 64'hFFFF) + (lo >> 32)) >> 16);
	endfunction

	// Unsigned quotient by shift and subtract, evaluated only while the table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Returns exp(-r / 4096) in Q48 for r in 0 to 4096.
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] r);
		logic [63:0] term;
		logic [63:0] acc;
		term = Q48_ONE;
		acc  = Q48_ONE;
		for (int k = 1; k <= 24; k++) begin
			term = udiv64(term * r, 64'd4096 * 64'(k));
			if (k[0]) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		return acc;
	endfunction

	// Sigmoid of the lowest value of a bucket, rounded, in Q1.12.
	function automatic act_t sig_entry(input int idx);
		longint      x;
		logic [63:0] t;
		logic [63:0] n;
		logic [63:0] e;
		logic [63:0] e1;
		logic [63:0] num;
		logic [63:0] den;
		x  = -(longint'(1) << (SAMPLE_BITS - 1))
			+ longint'(idx) * (longint'(1) << (SAMPLE_BITS - INDEX_BITS));
		t  = (x < 0) ? 64'(-x) : 64'(x);
		n  = t >> FRAC_SHIFT;
		e1 = exp_neg_frac(64'd4096);
		e  = exp_neg_frac(t & 64'd4095);
		for (int k = 0; k < 64; k++) begin
			if (64'(k) < n) begin
				e = mul_q48(e, e1);
			end
		end
		den = Q48_ONE + e;
		num = (x >= 0) ? (64'd4096 << 48) : (64'd4096 * e);
		return ACT_BITS'(udiv64(num + (den >> 1), den));
	endfunction

endpackage

>>> rtl/local_window_sigmoid_neuron_top.sv
// ----------------------------------------------------------------------------
// local_window_sigmoid_neuron_top: locally connected layer with sigmoid
// Keeps the last two samples, forms the weighted window sum of each full
// window, adds the bias, saturates and looks up the sigmoid table.
// ----------------------------------------------------------------------------
// An accepted input beat is registered as products in the product stage;
// the sum and table stage then fills the output register. Throughput: one
// input beat per cycle while the output is not stalled. Reset clears the
// window, the fill count, the bias and all valid flags at once.
// ----------------------------------------------------------------------------
module local_window_sigmoid_neuron_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sample, weight_oldest, weight_middle, weight_newest (lowest bit first)
	input  logic [lwsn_pkg::S_DATA_BITS-1:0]   s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// activation, zero fill (lowest bit first)
	output logic [lwsn_pkg::M_DATA_BITS-1:0]   m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lwsn_pkg::SAMPLE_BITS-1:0]   cfg_data
);

	localparam int SB = lwsn_pkg::SAMPLE_BITS;

	lwsn_pkg::act_t    sig_rom [lwsn_pkg::TABLE_SIZE];

	lwsn_pkg::sample_t bias_q;
	lwsn_pkg::sample_t win_q [lwsn_pkg::WIN_DEPTH];
	logic [lwsn_pkg::FILL_BITS-1:0] fill_q;

	lwsn_pkg::prod_t   prod_s1 [lwsn_pkg::TAPS];
	logic              last_s1;
	logic              valid_s1;

	lwsn_pkg::act_t    act_q;
	logic              last_q;
	logic              m_valid_q;

	logic              in_beat;
	logic              out_adv;
	logic              s1_adv;
	logic              full;
	lwsn_pkg::sample_t cur_sample;
	lwsn_pkg::sample_t tap_sample [lwsn_pkg::TAPS];
	lwsn_pkg::sample_t tap_weight [lwsn_pkg::TAPS];

	logic signed [lwsn_pkg::SUM_BITS-1:0]    sum;
	logic signed [lwsn_pkg::SHIFT_BITS-1:0]  shifted;
	logic signed [lwsn_pkg::BIASED_BITS-1:0] biased;
	lwsn_pkg::sample_t                       sat;
	logic [SB-1:0]                           sat_off;
	logic [lwsn_pkg::INDEX_BITS-1:0]         idx;

	for (genvar i = 0; i < lwsn_pkg::TABLE_SIZE; i++) begin : g_rom
		localparam lwsn_pkg::act_t ENTRY = lwsn_pkg::sig_entry(i);
		assign sig_rom[i] = ENTRY;
	end

	assign out_adv   = !m_valid_q || m_tready;
	assign s1_adv    = !valid_s1 || out_adv;
	assign s_tready  = s1_adv;
	assign in_beat   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign full      = (fill_q >= lwsn_pkg::FILL_BITS'(lwsn_pkg::WIN_DEPTH));

	assign cur_sample = s_tdata[SB-1:0];

	always_comb begin
		for (int j = 0; j < lwsn_pkg::TAPS; j++) begin
			tap_weight[j] = s_tdata[(j+1)*SB +: SB];
			if (j < lwsn_pkg::WIN_DEPTH) begin
				tap_sample[j] = win_q[j];
			end else begin
				tap_sample[j] = cur_sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			bias_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < lwsn_pkg::WIN_DEPTH; j++) begin
				win_q[j] <= '0;
			end
			fill_q <= '0;
		end else if (in_beat) begin
			if (s_tlast) begin
				for (int j = 0; j < lwsn_pkg::WIN_DEPTH; j++) begin
					win_q[j] <= '0;
				end
				fill_q <= '0;
			end else begin
				for (int j = 0; j < lwsn_pkg::WIN_DEPTH - 1; j++) begin
					win_q[j] <= win_q[j+1];
				end
				win_q[lwsn_pkg::WIN_DEPTH-1] <= cur_sample;
				if (!full) begin
					fill_q <= fill_q + lwsn_pkg::FILL_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= in_beat && full;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_beat) begin
			for (int j = 0; j < lwsn_pkg::TAPS; j++) begin
				prod_s1[j] <= lwsn_pkg::PROD_BITS'(tap_sample[j])
					* lwsn_pkg::PROD_BITS'(tap_weight[j]);
			end
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		sum = '0;
		for (int j = 0; j < lwsn_pkg::TAPS; j++) begin
			sum = sum + lwsn_pkg::SUM_BITS'(prod_s1[j]);
		end
		shifted = lwsn_pkg::SHIFT_BITS'(sum >>> lwsn_pkg::FRAC_SHIFT);
		biased  = lwsn_pkg::BIASED_BITS'(shifted) + lwsn_pkg::BIASED_BITS'(bias_q);
		if ((biased[lwsn_pkg::BIASED_BITS-1:SB-1] == '0)
			|| (biased[lwsn_pkg::BIASED_BITS-1:SB-1] == '1)) begin
			sat = biased[SB-1:0];
		end else if (biased[lwsn_pkg::BIASED_BITS-1]) begin
			sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SB-1){1'b1}}};
		end
		sat_off = {~sat[SB-1], sat[SB-2:0]};
		idx     = sat_off[SB-1 -: lwsn_pkg::INDEX_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			act_q  <= sig_rom[idx];
			last_q <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = lwsn_pkg::M_DATA_BITS'(act_q);
	assign m_tlast  = last_q;

endmodule

>>> rtl/lwsn_checker.sv
// ----------------------------------------------------------------------------
// lwsn_checker: port-level checks for the local window sigmoid neuron
// Watches the stream and configuration ports of the top level.
// ----------------------------------------------------------------------------
module lwsn_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [lwsn_pkg::S_DATA_BITS-1:0] s_tdata,
	input logic                             s_tlast,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lwsn_pkg::M_DATA_BITS-1:0] m_tdata,
	input logic                             m_tlast,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);

	// An activation never exceeds 1.0 and the fill bits stay clear.
	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata <= lwsn_pkg::M_DATA_BITS'(4096)))
		else $error("activation out of range");

	// A free or draining output always lets the input side move.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output is free");

	// A stalled result beat holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("result beat changed while stalled");

	// A stalled input beat stays offered with the same data.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tlast)))
		else $error("input beat changed while stalled");

	// The configuration channel never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind local_window_sigmoid_neuron_top lwsn_checker u_lwsn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.s_tlast   (s_tlast),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
